>>> hw/rtl/stpg_pkg.sv
// Package of the stepper step pulse generator.
// Holds widths, register codes, reset values and the command structs.
// Used by every other RTL file but stpg_checker; depends on nothing.
`default_nettype none

package stpg_pkg;

    // Field and storage widths.
    localparam int HP_W        = 16;   // half period in base ticks
    localparam int SC_W        = 32;   // step counter
    localparam int STEP_CNT_W  = 32;   // step_count field
    localparam int RPM_W       = 16;
    localparam int SPR_W       = 16;
    localparam int TICK_RATE_W = 27;

    // Divider width and its step counter.
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_REV = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE_HZ  = 1'd1;

    localparam logic [SPR_W-1:0]       SPR_RESET       = 16'd200;
    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RESET = 27'd1000000;

    // Steps per second are rpm times steps per revolution over sixty. The
    // product is divided by four with a shift, then by fifteen through the
    // reciprocal 2^34 / 15 rounded up, which is exact for any 30-bit value.
    localparam int SPS_PRE_SHIFT = 2;
    localparam int SPS_RECIP_W   = 31;
    localparam int SPS_SHIFT     = 34;
    localparam logic [SPS_RECIP_W-1:0] SPS_RECIP = 31'd1145324613;
    localparam int SPS_MUL_W     = DIV_W - SPS_PRE_SHIFT + SPS_RECIP_W;

    // Largest half period, held one bit wider than the divider word.
    localparam logic [DIV_W:0] HP_MAX_EXT = (33'd1 << HP_W) - 33'd1;

    // Command codes of an input item.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_quick;   // item finished as it is taken
        logic begin_move;     // start command taken, product registered
        logic div_step;       // advance the divider by one bit
        logic div_second;     // scale to steps per second, start the divider
        logic finish;         // apply the computed half period
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic long_start;     // start item that needs the divider
        logic div_done;       // divider has no bits left
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/stpg_if.sv
// Valid/ready channel interfaces of the stepper step pulse generator.
// One interface for input items and one for result items; uses stpg_pkg.
`default_nettype none

interface stpg_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [stpg_pkg::STEP_CNT_W-1:0]   step_count;
    logic                              direction;
    logic [stpg_pkg::RPM_W-1:0]        speed_rpm;

    modport source (output valid, command, step_count, direction, speed_rpm,
                    input ready);
    modport sink   (input valid, command, step_count, direction, speed_rpm,
                    output ready);
endinterface

interface stpg_out_if;
    logic valid;
    logic ready;
    logic step_level;
    logic dir_level;
    logic busy_res;
    logic done_res;
    logic error;

    modport source (output valid, step_level, dir_level, busy_res, done_res, error,
                    input ready);
    modport sink   (input valid, step_level, dir_level, busy_res, done_res, error,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stpg_div.sv
// Radix-2 restoring divider, one quotient bit per step.
// Divides the tick rate by the steps per second at a move start; uses stpg_pkg.
`default_nettype none

module stpg_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic                       i_step,
    input  wire logic [stpg_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [stpg_pkg::DIV_W-1:0] i_divisor,
    output logic      [stpg_pkg::DIV_W-1:0] o_quotient,
    output logic                            o_done
);

    logic [stpg_pkg::DIV_W-1:0]     r_rem, n_rem;
    logic [stpg_pkg::DIV_W-1:0]     r_quo, n_quo;
    logic [stpg_pkg::DIV_W-1:0]     r_div;
    logic [stpg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [stpg_pkg::DIV_W:0]       rem_sh;
    logic [stpg_pkg::DIV_W+1:0]     diff;
    logic                           fits;

    assign o_done     = (r_cnt == stpg_pkg::DIV_CNT_W'(stpg_pkg::DIV_W));
    assign o_quotient = r_quo;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
        rem_sh = {r_rem, r_quo[stpg_pkg::DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        fits   = !diff[stpg_pkg::DIV_W+1];
        n_rem  = fits ? diff[stpg_pkg::DIV_W-1:0] : rem_sh[stpg_pkg::DIV_W-1:0];
        n_quo  = {r_quo[stpg_pkg::DIV_W-2:0], fits};
    end

    // The step counter is control state; it rests at the done value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= stpg_pkg::DIV_CNT_W'(stpg_pkg::DIV_W);
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // The quotient register holds the dividend bits until they shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (i_step && !o_done) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stpg_datapath.sv
// Datapath of the stepper step pulse generator: configuration registers,
// motion state, the divider and the result register.
// Depends on stpg_pkg and stpg_div.
`default_nettype none

module stpg_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire stpg_pkg::t_ctrl_cmd             i_cmd,
    output stpg_pkg::t_dp_status                 o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [stpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_command,
    input  wire logic [stpg_pkg::STEP_CNT_W-1:0] i_step_count,
    input  wire logic                            i_direction,
    input  wire logic [stpg_pkg::RPM_W-1:0]      i_speed_rpm,
    output logic                                 o_step_level,
    output logic                                 o_dir_level,
    output logic                                 o_busy_res,
    output logic                                 o_done_res,
    output logic                                 o_error
);

    // Configuration.
    logic [stpg_pkg::SPR_W-1:0]       r_spr;
    logic [stpg_pkg::TICK_RATE_W-1:0] r_tick_rate;

    // Motion state.
    logic                      r_dir, n_dir;
    logic                      r_step, n_step;
    logic                      r_busy, n_busy;
    logic [stpg_pkg::HP_W-1:0] r_half, n_half;
    logic [stpg_pkg::HP_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [stpg_pkg::SC_W-1:0] r_steps_left, n_steps_left;

    // Move operands held while the divider runs.
    logic [stpg_pkg::SC_W-1:0]  r_cnt_pend;
    logic [stpg_pkg::DIV_W-1:0] r_prod;
    logic [stpg_pkg::DIV_W-1:0] r_sps;

    // Result payload.
    logic r_o_step, r_o_dir, r_o_busy, r_o_done, r_o_err;
    logic n_done, n_err;

    // Divider hookup.
    logic                           div_start;
    logic [stpg_pkg::DIV_W-1:0]     div_dividend;
    logic [stpg_pkg::DIV_W-1:0]     div_divisor;
    logic [stpg_pkg::DIV_W-1:0]     div_quo;
    logic                           div_done;
    logic [stpg_pkg::DIV_W-1:0]     prod;
    logic [stpg_pkg::SPS_MUL_W-1:0] sps_wide;
    logic [stpg_pkg::DIV_W-1:0]     sps;
    logic [stpg_pkg::DIV_W-2:0]     half_q;
    logic [stpg_pkg::HP_W-1:0]      half_sat;
    logic                           load_out;

    assign o_status.long_start = (i_command == stpg_pkg::CMD_START) && !r_busy
                                 && (i_speed_rpm != '0);
    assign o_status.div_done   = div_done;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr       <= stpg_pkg::SPR_RESET;
            r_tick_rate <= stpg_pkg::TICK_RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stpg_pkg::REG_STEPS_PER_REV: r_spr <= i_cfg_data[stpg_pkg::SPR_W-1:0];
                stpg_pkg::REG_TICK_RATE_HZ:  r_tick_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The product rpm times steps per revolution is registered when the
    // start command is taken; the next cycle scales it by one sixtieth and
    // hands the tick rate and the steps per second to the divider.
    assign prod     = stpg_pkg::DIV_W'(i_speed_rpm) * stpg_pkg::DIV_W'(r_spr);
    assign sps_wide = stpg_pkg::SPS_MUL_W'(r_prod[stpg_pkg::DIV_W-1:stpg_pkg::SPS_PRE_SHIFT])
                      * stpg_pkg::SPS_MUL_W'(stpg_pkg::SPS_RECIP);
    assign sps      = stpg_pkg::DIV_W'(sps_wide >> stpg_pkg::SPS_SHIFT);

    assign div_start    = i_cmd.div_second;
    assign div_dividend = stpg_pkg::DIV_W'(r_tick_rate);
    assign div_divisor  = sps;

    stpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_step     (i_cmd.div_step),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    // Halve the quotient and clamp it to the half period range.
    always_comb begin
        half_q = div_quo[stpg_pkg::DIV_W-1:1];
        if ({2'b00, half_q} > stpg_pkg::HP_MAX_EXT) begin
            half_sat = '1;
        end else begin
            half_sat = stpg_pkg::HP_W'({2'b00, half_q});
        end
    end

    // Next motion state for an item finished without the divider, the taking of a move start, or its end.
    always_comb begin
        n_dir        = r_dir;
        n_step       = r_step;
        n_busy       = r_busy;
        n_half       = r_half;
        n_tick_cnt   = r_tick_cnt;
        n_steps_left = r_steps_left;
        n_done       = 1'b0;
        n_err        = 1'b0;

        if (i_cmd.accept_quick) begin
            if (i_command == stpg_pkg::CMD_START) begin
                // Refused start: busy, or zero speed (then the direction is still latched).
                n_err = 1'b1;
                if (!r_busy) begin
                    n_dir = i_direction;
                end
            end else if (r_busy) begin
                n_tick_cnt = r_tick_cnt + 1'b1;
                if (n_tick_cnt >= r_half) begin
                    n_tick_cnt = '0;
                    if (r_step) begin
                        n_step = 1'b0;
                    end else begin
                        n_steps_left = r_steps_left - 1'b1;
                        if (n_steps_left == '0) begin
                            n_busy = 1'b0;
                            n_done = 1'b1;
                        end else begin
                            n_step = 1'b1;
                        end
                    end
                end
            end
        end else if (i_cmd.begin_move) begin
            n_dir = i_direction;
        end else if (i_cmd.finish) begin
            if (r_sps == '0 || half_sat == '0) begin
                n_err = 1'b1;
            end else if (r_cnt_pend == '0) begin
                n_done = 1'b1;
            end else begin
                n_half       = half_sat;
                n_tick_cnt   = '0;
                n_steps_left = r_cnt_pend;
                n_step       = 1'b1;
                n_busy       = 1'b1;
            end
        end
    end

    // Motion state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir        <= 1'b0;
            r_step       <= 1'b0;
            r_busy       <= 1'b0;
            r_half       <= '0;
            r_tick_cnt   <= '0;
            r_steps_left <= '0;
        end else begin
            r_dir        <= n_dir;
            r_step       <= n_step;
            r_busy       <= n_busy;
            r_half       <= n_half;
            r_tick_cnt   <= n_tick_cnt;
            r_steps_left <= n_steps_left;
        end
    end

    // Operands kept for the end of a move start.
    always_ff @(posedge i_clk) begin
        if (i_cmd.begin_move) begin
            r_cnt_pend <= i_step_count[stpg_pkg::SC_W-1:0];
            r_prod     <= prod;
        end
        if (i_cmd.div_second) begin
            r_sps <= sps;
        end
    end

    // Result register, loaded whenever an item completes.
    assign load_out = i_cmd.accept_quick || i_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_step <= n_step;
            r_o_dir  <= n_dir;
            r_o_busy <= n_busy;
            r_o_done <= n_done;
            r_o_err  <= n_err;
        end
    end

    assign o_step_level = r_o_step;
    assign o_dir_level  = r_o_dir;
    assign o_busy_res   = r_o_busy;
    assign o_done_res   = r_o_done;
    assign o_error      = r_o_err;

endmodule

`default_nettype wire

>>> hw/rtl/stpg_ctrl.sv
// Controller of the stepper step pulse generator: handshakes, the result
// valid flag and the sequence of a move start through the divider.
// Depends on stpg_pkg.
`default_nettype none

module stpg_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire stpg_pkg::t_dp_status i_status,
    output stpg_pkg::t_ctrl_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE     = 3'b001,
        S_DIV_SPS  = 3'b010,
        S_DIV_HALF = 3'b100
    } t_ctrl_state;

    t_ctrl_state r_state, n_state;
    logic        r_out_valid;
    logic        out_free;
    logic        accept;

    // The result register may be loaded when empty or being emptied.
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Item acceptance and the sequencing of a move start: scale the product, run the divider, load the result.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_status.long_start) begin
                        o_cmd.begin_move = 1'b1;
                        n_state          = S_DIV_SPS;
                    end else begin
                        o_cmd.accept_quick = 1'b1;
                    end
                end
            end
            S_DIV_SPS: begin
                o_cmd.div_second = 1'b1;
                n_state          = S_DIV_HALF;
            end
            S_DIV_HALF: begin
                if (!i_status.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.accept_quick || o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stepper_step_pulse_generator_core.sv
// Top level of the stepper step pulse generator.
// Joins stpg_ctrl and stpg_datapath to the channel interfaces of stpg_if.
//
// Each input item gives exactly one result item. A tick item, and a start
// command that is refused at once (busy, or zero speed), is finished as
// it is taken, so ticks stream at one per cycle while results are taken.
// A start command with a nonzero speed while not busy holds the input while
// it takes the command and registers rpm times the steps per revolution,
// scales that by one sixtieth into steps per second and loads the divider,
// runs the radix-2 divider bit by bit for the tick rate over the steps per
// second, and loads the result. A new item is taken only in the idle state
// while the result register is empty or being read in the same cycle, so a
// consumer that holds off stalls the input as soon as one result waits.
`default_nettype none

module stepper_step_pulse_generator_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    stpg_in_if.sink                              i_in,
    stpg_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [stpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [stpg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    stpg_pkg::t_ctrl_cmd  ctrl_cmd;
    stpg_pkg::t_dp_status dp_status;

    stpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (dp_status),
        .o_cmd       (ctrl_cmd)
    );

    stpg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctrl_cmd),
        .o_status     (dp_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_command    (i_in.command),
        .i_step_count (i_in.step_count),
        .i_direction  (i_in.direction),
        .i_speed_rpm  (i_in.speed_rpm),
        .o_step_level (o_out.step_level),
        .o_dir_level  (o_out.dir_level),
        .o_busy_res   (o_out.busy_res),
        .o_done_res   (o_out.done_res),
        .o_error      (o_out.error)
    );

endmodule

`default_nettype wire

>>> hw/rtl/stpg_checker.sv
// Port-level checks of the stepper step pulse generator and their binding.
// Depends only on the ports of stepper_step_pulse_generator_core.
`default_nettype none

module stpg_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_step_level,
    input wire logic i_dir_level,
    input wire logic i_busy_res,
    input wire logic i_done_res,
    input wire logic i_error
);

    // A finished move and a refused command are never the same item.
    a_done_not_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_done_res && i_error))
        else $error("done and error on the same item");

    // The item that finishes a move leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_done_res) |-> (!i_busy_res && !i_step_level))
        else $error("move finished but still busy or pulsing");

    // A high step level only occurs during a move.
    a_step_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_step_level) |-> i_busy_res)
        else $error("step pulse outside a move");

    // A stalled item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_step_level) && $stable(i_dir_level)
             && $stable(i_busy_res) && $stable(i_done_res) && $stable(i_error)))
        else $error("stalled item changed");

endmodule

bind stepper_step_pulse_generator_core stpg_checker u_stpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_step_level (o_out.step_level),
    .i_dir_level  (o_out.dir_level),
    .i_busy_res   (o_out.busy_res),
    .i_done_res   (o_out.done_res),
    .i_error      (o_out.error)
);

`default_nettype wire

>>> dv/stepper_step_pulse_generator_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of stepper_step_pulse_generator_core.
// Drives move and tick items, predicts every result item with its own step model
// and compares them in order. Depends on stpg_pkg, stpg_if and the core RTL.

module stepper_step_pulse_generator_core_test;

    localparam int LIMIT_CYCLES = 400_000;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [63:0] HALF_MAX = (64'd1 << stpg_pkg::HP_W) - 64'd1;

    // One expected result item.
    typedef struct packed {
        logic step_level;
        logic dir_level;
        logic busy_res;
        logic done_res;
        logic error;
    } t_pulse_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [stpg_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [stpg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    stpg_in_if  in_if ();
    stpg_out_if out_if ();

    stepper_step_pulse_generator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Copy of the configuration as the block should hold it.
    logic [stpg_pkg::SPR_W-1:0]       cfg_spr;
    logic [stpg_pkg::TICK_RATE_W-1:0] cfg_tick_rate;

    // Step model state.
    logic                      mdl_dir;
    logic                      mdl_step;
    logic                      mdl_busy;
    logic [stpg_pkg::HP_W-1:0] mdl_half;
    logic [stpg_pkg::HP_W-1:0] mdl_ticks;
    logic [stpg_pkg::SC_W-1:0] mdl_left;

    t_pulse_result expected_pulses[$];
    t_pulse_result oldest_pulse;

    int fail_count    = 0;
    int cycle_count   = 0;
    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int moved_items   = 0;

    // Clock with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Half period in base ticks for a speed, saturated; zero means refused.
    function automatic logic [stpg_pkg::HP_W-1:0] half_period_of(
            input logic [stpg_pkg::RPM_W-1:0] rpm);
        logic [63:0] sps;
        logic [63:0] half;
        sps = 64'(rpm);
        sps = (sps * 64'(cfg_spr)) / 64'd60;
        if (rpm == '0 || sps == 64'd0) begin
            return '0;
        end
        half = 64'(cfg_tick_rate);
        half = (half / sps) / 64'd2;
        if (half > HALF_MAX) begin
            half = HALF_MAX;
        end
        return half[stpg_pkg::HP_W-1:0];
    endfunction

    // Advances the step model by one item and gives its result.
    task automatic predict_pulse(input logic cmd,
                                 input logic [stpg_pkg::STEP_CNT_W-1:0] cnt,
                                 input logic dir, input logic [stpg_pkg::RPM_W-1:0] rpm,
                                 output t_pulse_result res);
        logic [stpg_pkg::HP_W-1:0] half;
        res = '0;
        if (cmd == stpg_pkg::CMD_START) begin
            if (mdl_busy) begin
                res.error = 1'b1;
            end else begin
                mdl_dir = dir;
                half = half_period_of(rpm);
                if (half == '0) begin
                    res.error = 1'b1;
                end else if (cnt[stpg_pkg::SC_W-1:0] == '0) begin
                    res.done_res = 1'b1;
                end else begin
                    mdl_half  = half;
                    mdl_ticks = '0;
                    mdl_left  = cnt[stpg_pkg::SC_W-1:0];
                    mdl_step  = 1'b1;
                    mdl_busy  = 1'b1;
                end
            end
        end else if (mdl_busy) begin
            mdl_ticks = mdl_ticks + 1'b1;
            if (mdl_ticks >= mdl_half) begin
                mdl_ticks = '0;
                if (mdl_step) begin
                    mdl_step = 1'b0;
                end else begin
                    mdl_left = mdl_left - 1'b1;
                    if (mdl_left == '0) begin
                        mdl_busy = 1'b0;
                        res.done_res = 1'b1;
                    end else begin
                        mdl_step = 1'b1;
                    end
                end
            end
        end
        res.step_level = mdl_step;
        res.dir_level  = mdl_dir;
        res.busy_res   = mdl_busy;
    endtask

    // Offers one item after a random gap and waits until it is taken.
    task automatic send_item(input logic cmd, input logic [stpg_pkg::STEP_CNT_W-1:0] cnt,
                             input logic dir, input logic [stpg_pkg::RPM_W-1:0] rpm);
        t_pulse_result res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= cmd;
        in_if.step_count <= cnt;
        in_if.direction  <= dir;
        in_if.speed_rpm  <= rpm;
        predict_pulse(cmd, cnt, dir, rpm, res);
        expected_pulses.push_back(res);
        do begin
            @(posedge i_clk);
        end while (in_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // Tick item with random content in the ignored fields.
    task automatic send_tick();
        send_item(stpg_pkg::CMD_TICK, stpg_pkg::STEP_CNT_W'($urandom),
                  1'($urandom_range(0, 1)), stpg_pkg::RPM_W'($urandom_range(0, 65535)));
    endtask

    // Start command with every field random.
    task automatic send_random_start();
        send_item(stpg_pkg::CMD_START, stpg_pkg::STEP_CNT_W'($urandom),
                  1'($urandom_range(0, 1)), stpg_pkg::RPM_W'($urandom_range(0, 65535)));
    endtask

    // Sends ticks until the model says the running move is over.
    task automatic run_out_move();
        while (mdl_busy) begin
            send_tick();
        end
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_pulses.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes both registers while the block is idle.
    task automatic set_config(input logic [stpg_pkg::SPR_W-1:0] spr,
                              input logic [stpg_pkg::TICK_RATE_W-1:0] rate);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= stpg_pkg::REG_STEPS_PER_REV;
        i_cfg_data <= stpg_pkg::CFG_DATA_W'(spr);
        @(negedge i_clk);
        i_cfg_idx  <= stpg_pkg::REG_TICK_RATE_HZ;
        i_cfg_data <= stpg_pkg::CFG_DATA_W'(rate);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_spr       = spr;
        cfg_tick_rate = rate;
    endtask

    // Looks for a speed whose half period lies in 1..max_half.
    task automatic pick_speed(input int max_half, output logic [stpg_pkg::RPM_W-1:0] rpm,
                              output bit found);
        logic [stpg_pkg::HP_W-1:0] half;
        int tries;
        found = 1'b0;
        rpm   = '0;
        for (tries = 0; tries < 60 && !found; tries++) begin
            case ($urandom_range(0, 2))
                0: rpm = stpg_pkg::RPM_W'($urandom_range(0, 65535));
                1: rpm = stpg_pkg::RPM_W'($urandom_range(1, 255));
                default: rpm = stpg_pkg::RPM_W'($urandom_range(256, 8191));
            endcase
            half = half_period_of(rpm);
            if (half != '0 && half <= max_half) begin
                found = 1'b1;
            end
        end
    endtask

    // Tick while idle, then refusals for zero speed, each latching the direction.
    task automatic test_idle_and_refusals();
        send_item(stpg_pkg::CMD_TICK, '1, 1'b1, '1);
        send_item(stpg_pkg::CMD_START, 32'd5, 1'b1, 16'd0);
        send_item(stpg_pkg::CMD_START, 32'd5, 1'b0, 16'd0);
        send_item(stpg_pkg::CMD_START, '1, 1'b1, 16'd0);
    endtask

    // Zero step count, then a full two-pulse move at top speed.
    task automatic test_move_and_done();
        send_item(stpg_pkg::CMD_START, 32'd0, 1'b0, 16'hFFFF);
        send_item(stpg_pkg::CMD_START, 32'd2, 1'b1, 16'hFFFF);
        run_out_move();
        send_tick();
    endtask

    // A start command during a move is refused and leaves the direction alone.
    task automatic test_start_while_busy();
        send_item(stpg_pkg::CMD_START, 32'd1, 1'b0, 16'hFFFF);
        send_item(stpg_pkg::CMD_START, '1, 1'b1, 16'd0);
        send_item(stpg_pkg::CMD_START, 32'd3, 1'b1, 16'hFFFF);
        run_out_move();
    endtask

    // Register extremes: a product below sixty, a product of sixty, and a zero half period.
    task automatic test_config_extremes();
        set_config(16'd1, 27'd80_000_000);
        send_item(stpg_pkg::CMD_START, 32'd4, 1'b1, 16'd59);
        send_item(stpg_pkg::CMD_START, 32'd0, 1'b0, 16'd60);
        set_config(16'hFFFF, 27'd1);
        send_item(stpg_pkg::CMD_START, 32'd5, 1'b1, 16'hFFFF);
        send_item(stpg_pkg::CMD_START, 32'd5, 1'b0, 16'd1);
    endtask

    // Mostly short well-formed moves with random content, plus noise.
    task automatic test_random_moves(input int item_goal);
        logic [stpg_pkg::RPM_W-1:0] rpm;
        logic [stpg_pkg::STEP_CNT_W-1:0] cnt;
        logic [63:0] need;
        bit found;
        int kind;
        int goal;
        goal = moved_items + item_goal;
        while (moved_items < goal) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_tick();
            end else begin
                if (kind <= 2) begin
                    // Fully random start; long moves are cut to zero steps.
                    rpm  = stpg_pkg::RPM_W'($urandom_range(0, 65535));
                    cnt  = stpg_pkg::STEP_CNT_W'($urandom);
                    need = 64'(half_period_of(rpm));
                    need = need * 64'(cnt) * 64'd2;
                    if (need > 64'd64) begin
                        cnt = '0;
                    end
                end else begin
                    pick_speed(6, rpm, found);
                    cnt = found ? stpg_pkg::STEP_CNT_W'($urandom_range(1, 4)) : '0;
                end
                send_item(stpg_pkg::CMD_START, cnt, 1'($urandom_range(0, 1)), rpm);
                moved_items++;
                // Ticks through the move, with refused starts mixed in.
                while (mdl_busy) begin
                    if ($urandom_range(0, 15) == 0) begin
                        send_random_start();
                    end else begin
                        send_tick();
                        moved_items++;
                    end
                end
            end
        end
    endtask

    // The receiver stops for a long stretch while a move keeps the input busy.
    task automatic test_receiver_hold();
        logic [stpg_pkg::RPM_W-1:0] rpm;
        bit found;
        pick_speed(6, rpm, found);
        hold_request = 200;
        send_item(stpg_pkg::CMD_START, found ? 32'd3 : 32'd0, 1'b1, rpm);
        run_out_move();
        repeat (30) send_tick();
    endtask

    // A half period just above the 16-bit range saturates, so the step level
    // stays high through ticks that a wrapped period of three would end.
    task automatic test_saturated_long_move();
        set_config(16'd1, 27'd131_078);
        send_item(stpg_pkg::CMD_START, '1, 1'b1, 16'd60);
        repeat (10) send_tick();
    endtask

    // Receiver ready, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic void check_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0b, actual %0b", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Compares each accepted result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_pulses.size() == 0) begin
                $error("result item with no expectation waiting");
                fail_count++;
            end else begin
                oldest_pulse = expected_pulses.pop_front();
                check_field("step_level", oldest_pulse.step_level, out_if.step_level);
                check_field("dir_level", oldest_pulse.dir_level, out_if.dir_level);
                check_field("busy_res", oldest_pulse.busy_res, out_if.busy_res);
                check_field("done_res", oldest_pulse.done_res, out_if.done_res);
                check_field("error", oldest_pulse.error, out_if.error);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.command    = stpg_pkg::CMD_TICK;
        in_if.step_count = '0;
        in_if.direction  = 1'b0;
        in_if.speed_rpm  = '0;
        out_if.ready     = 1'b0;
        cfg_spr       = stpg_pkg::SPR_RESET;
        cfg_tick_rate = stpg_pkg::TICK_RATE_RESET;
        mdl_dir   = 1'b0;
        mdl_step  = 1'b0;
        mdl_busy  = 1'b0;
        mdl_half  = '0;
        mdl_ticks = '0;
        mdl_left  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles rarely, receiver often; reset configuration first.
        src_idle_pct = 9;
        snk_idle_pct = 56;
        test_idle_and_refusals();
        test_move_and_done();
        test_start_while_busy();
        test_config_extremes();
        set_config(16'd200, 27'd2000);
        test_random_moves(240);

        // Sender idles often, receiver rarely; top steps per revolution, tick rate 80_000_000.
        src_idle_pct = 56;
        snk_idle_pct = 9;
        set_config(16'hFFFF, 27'd80_000_000);
        test_random_moves(240);
        test_receiver_hold();

        // No idling on either side.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_config(stpg_pkg::SPR_W'($urandom_range(1, 65535)),
                   stpg_pkg::TICK_RATE_W'($urandom_range(1, 80_000_000)));
        test_random_moves(240);
        test_saturated_long_move();

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
